/* rtl/twdq_pkg.sv */
// Package for the timed wait delta queue.
// Holds the operation and reason codes, the queue entry type and fixed limits.
// No dependencies.
package twdq_pkg;

    localparam int unsigned IdW        = 10;
    localparam int unsigned DeltaW     = 16;
    localparam int unsigned MaxResults = 16;
    localparam int unsigned NumW       = 5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SIGNAL = 2'd1,
        OP_TICK   = 2'd2,
        OP_REMOVE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        RSN_TIMEOUT = 2'd0,
        RSN_SIGNAL  = 2'd1,
        RSN_REMOVED = 2'd2,
        RSN_FULL    = 2'd3
    } t_reason;

    typedef struct packed {
        logic [IdW-1:0]    tid;
        logic [DeltaW-1:0] delta;
        logic              fvr;
    } t_entry;

endpackage

/* rtl/timed_wait_delta_queue_unit.sv */
// Timed wait delta queue: top level with entry memory and sequencer.
// Depends on twdq_pkg.
//
// Usage:
// The input channel (i_valid, o_stall, i_operation, i_task_id, i_timeout) takes
// one command beat at a time: insert, signal head, clock tick or remove by id.
// o_stall is high while a command is being worked on; a new beat is taken only
// when the sequencer is idle.
// The output channel (o_valid, i_stall, o_released_id, o_reason, o_last) gives
// the result beats of a command; o_last marks the final beat of that command.
// Commands that cause no result give no beat.
// Entries sit in one memory of CAPACITY words with a registered read.
// The sequencer walks the memory step by step: scan, shift up, shift down.
// Insert of a forever entry or into an empty queue writes at once; other inserts
// scan for the place and then move the later entries up.
// Signal takes the head and remove scans for the id; both move later entries down.
// Tick counts down the head and releases the entries whose delta reaches zero.
// The sequencer waits in its emit step while a previous beat is still held
// by i_stall; one output register lets it move on while the last beat waits.
// Reset empties the queue at once; memory contents are not cleared.
module timed_wait_delta_queue_unit
    import twdq_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_operation,
    input  logic [IdW-1:0]       i_task_id,
    input  logic [DeltaW-1:0]    i_timeout,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [IdW-1:0]       o_released_id,
    output logic [1:0]           o_reason,
    output logic                 o_last
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_INS_CHK   = 13'b0000000000010,
        S_UP_WR     = 13'b0000000000100,
        S_INS_FIX   = 13'b0000000001000,
        S_INS_PUT   = 13'b0000000010000,
        S_HEAD      = 13'b0000000100000,
        S_REM_CHK   = 13'b0000001000000,
        S_TICK_CHK  = 13'b0000010000000,
        S_TAKE      = 13'b0000100000000,
        S_DN_WR     = 13'b0001000000000,
        S_POST      = 13'b0010000000000,
        S_TICK_NEXT = 13'b0100000000000,
        S_EMIT      = 13'b1000000000000
    } t_state;

    t_entry         r_mem [CAPACITY];
    t_entry         r_rdata;

    t_state         r_state, n_state;
    t_state         r_ret, n_ret;
    logic [CW-1:0]  r_count, n_count;
    logic [AW-1:0]  r_idx, n_idx;
    logic [AW-1:0]  r_pos, n_pos;
    logic [DeltaW-1:0] r_rem, n_rem;
    t_entry         r_hold, n_hold;
    t_op            r_op, n_op;
    logic [IdW-1:0] r_id, n_id;
    logic [IdW-1:0] r_res_id, n_res_id;
    t_reason        r_res_rsn, n_res_rsn;
    logic           r_elast, n_elast;
    logic           r_tick_more, n_tick_more;
    logic [NumW-1:0] r_num, n_num;
    logic           r_ovalid, n_ovalid;
    logic [IdW-1:0] r_oid, n_oid;
    logic [1:0]     r_orsn, n_orsn;
    logic           r_olast, n_olast;

    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    t_entry         wr_data;

    logic           accept;
    logic [CW-1:0]  idx_next;
    logic [CW-1:0]  pos_next;
    logic [DeltaW:0] sat_sum;
    logic [DeltaW-1:0] dec_delta;

    assign o_stall       = (r_state != S_IDLE);
    assign accept        = i_valid && (r_state == S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_released_id = r_oid;
    assign o_reason      = r_orsn;
    assign o_last        = r_olast;

    assign idx_next  = CW'(r_idx) + CW'(1);
    assign pos_next  = CW'(r_pos) + CW'(1);
    assign sat_sum   = {1'b0, r_rdata.delta} + {1'b0, r_hold.delta};
    assign dec_delta = (r_rdata.delta == '0) ? '0 : r_rdata.delta - DeltaW'(1);

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_rem       = r_rem;
        n_hold      = r_hold;
        n_op        = r_op;
        n_id        = r_id;
        n_res_id    = r_res_id;
        n_res_rsn   = r_res_rsn;
        n_elast     = r_elast;
        n_tick_more = r_tick_more;
        n_num       = r_num;
        n_ovalid    = r_ovalid && i_stall;
        n_oid       = r_oid;
        n_orsn      = r_orsn;
        n_olast     = r_olast;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = r_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op  = t_op'(i_operation);
                    n_id  = i_task_id;
                    n_rem = i_timeout;
                    n_idx = '0;
                    n_pos = '0;
                    unique case (t_op'(i_operation))
                        OP_INSERT: begin
                            if (r_count >= CW'(CAPACITY)) begin
                                n_res_id  = i_task_id;
                                n_res_rsn = RSN_FULL;
                                n_elast   = 1'b1;
                                n_ret     = S_IDLE;
                                n_state   = S_EMIT;
                            end else if (i_timeout == '0 || r_count == '0) begin
                                wr_en   = 1'b1;
                                wr_addr = AW'(r_count);
                                wr_data = '{tid: i_task_id, delta: i_timeout,
                                            fvr: (i_timeout == '0)};
                                n_count = r_count + CW'(1);
                            end else begin
                                rd_en   = 1'b1;
                                n_state = S_INS_CHK;
                            end
                        end
                        OP_SIGNAL: begin
                            if (r_count != '0) begin
                                rd_en   = 1'b1;
                                n_state = S_HEAD;
                            end
                        end
                        OP_TICK: begin
                            if (r_count != '0) begin
                                rd_en   = 1'b1;
                                n_state = S_TICK_CHK;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_count != '0) begin
                                rd_en   = 1'b1;
                                n_state = S_REM_CHK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_INS_CHK: begin
                if (r_rdata.fvr || r_rdata.delta > r_rem) begin
                    n_pos  = r_idx;
                    n_hold = r_rdata;
                    if (r_count - CW'(1) > CW'(r_idx)) begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(r_count - CW'(1));
                        n_idx   = AW'(r_count - CW'(1));
                        n_state = S_UP_WR;
                    end else begin
                        n_state = S_INS_FIX;
                    end
                end else if (idx_next < r_count) begin
                    n_rem   = r_rem - r_rdata.delta;
                    rd_en   = 1'b1;
                    rd_addr = AW'(idx_next);
                    n_idx   = AW'(idx_next);
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(r_count);
                    wr_data = '{tid: r_id, delta: r_rem - r_rdata.delta, fvr: 1'b0};
                    n_count = r_count + CW'(1);
                    n_state = S_IDLE;
                end
            end
            S_UP_WR: begin
                wr_en   = 1'b1;
                wr_addr = AW'(idx_next);
                wr_data = r_rdata;
                if (CW'(r_idx) > pos_next) begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx - AW'(1);
                    n_idx   = r_idx - AW'(1);
                end else begin
                    n_state = S_INS_FIX;
                end
            end
            S_INS_FIX: begin
                wr_en   = 1'b1;
                wr_addr = AW'(pos_next);
                wr_data = r_hold;
                if (!r_hold.fvr) begin
                    wr_data.delta = r_hold.delta - r_rem;
                end
                n_state = S_INS_PUT;
            end
            S_INS_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_pos;
                wr_data = '{tid: r_id, delta: r_rem, fvr: 1'b0};
                n_count = r_count + CW'(1);
                n_state = S_IDLE;
            end
            S_HEAD: begin
                n_hold    = r_rdata;
                n_res_id  = r_rdata.tid;
                n_res_rsn = RSN_SIGNAL;
                n_pos     = '0;
                n_state   = S_TAKE;
            end
            S_REM_CHK: begin
                if (r_rdata.tid == r_id) begin
                    n_hold    = r_rdata;
                    n_res_id  = r_id;
                    n_res_rsn = RSN_REMOVED;
                    n_pos     = r_idx;
                    n_state   = S_TAKE;
                end else if (idx_next < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(idx_next);
                    n_idx   = AW'(idx_next);
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_TICK_CHK: begin
                if (r_rdata.fvr) begin
                    n_state = S_IDLE;
                end else if (dec_delta != '0) begin
                    wr_en         = 1'b1;
                    wr_addr       = '0;
                    wr_data       = r_rdata;
                    wr_data.delta = dec_delta;
                    n_state       = S_IDLE;
                end else begin
                    n_hold       = r_rdata;
                    n_hold.delta = '0;
                    n_res_id     = r_rdata.tid;
                    n_res_rsn    = RSN_TIMEOUT;
                    n_num        = NumW'(1);
                    n_pos        = '0;
                    n_state      = S_TAKE;
                end
            end
            S_TAKE: begin
                if (pos_next < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(pos_next);
                    n_idx   = AW'(pos_next);
                    n_state = S_DN_WR;
                end else begin
                    n_state = S_POST;
                end
            end
            S_DN_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_idx - AW'(1);
                wr_data = r_rdata;
                if (CW'(r_idx) == pos_next && !r_rdata.fvr) begin
                    wr_data.delta = sat_sum[DeltaW] ? '1 : sat_sum[DeltaW-1:0];
                end
                if (idx_next < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(idx_next);
                    n_idx   = AW'(idx_next);
                end else begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                n_count = r_count - CW'(1);
                if (r_op == OP_TICK && r_count != CW'(1)
                        && r_num != NumW'(MaxResults)) begin
                    rd_en   = 1'b1;
                    n_state = S_TICK_NEXT;
                end else begin
                    n_elast = 1'b1;
                    n_ret   = S_IDLE;
                    n_state = S_EMIT;
                end
            end
            S_TICK_NEXT: begin
                n_state = S_EMIT;
                if (!r_rdata.fvr && r_rdata.delta == '0) begin
                    n_hold      = r_rdata;
                    n_elast     = 1'b0;
                    n_tick_more = 1'b1;
                    n_ret       = S_TAKE;
                end else begin
                    n_elast = 1'b1;
                    n_ret   = S_IDLE;
                end
            end
            S_EMIT: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_oid    = r_res_id;
                    n_orsn   = r_res_rsn;
                    n_olast  = r_elast;
                    n_state  = r_ret;
                    if (r_tick_more) begin
                        n_tick_more = 1'b0;
                        n_res_id    = r_hold.tid;
                        n_num       = r_num + NumW'(1);
                        n_pos       = '0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_count     <= '0;
            r_ovalid    <= 1'b0;
            r_tick_more <= 1'b0;
            r_num       <= '0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_count     <= n_count;
            r_ovalid    <= n_ovalid;
            r_tick_more <= n_tick_more;
            r_num       <= n_num;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_rem     <= n_rem;
        r_hold    <= n_hold;
        r_op      <= n_op;
        r_id      <= n_id;
        r_res_id  <= n_res_id;
        r_res_rsn <= n_res_rsn;
        r_elast   <= n_elast;
        r_oid     <= n_oid;
        r_orsn    <= n_orsn;
        r_olast   <= n_olast;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("queue count above capacity");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_num_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_num <= NumW'(MaxResults))
        else $error("release count above limit");

    a_beat_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |=> r_ovalid)
        else $error("stalled result beat dropped");

    a_emit_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_ovalid && i_stall) |=> (r_state == S_EMIT))
        else $error("emit left while output slot busy");

endmodule

/* tb/timed_wait_delta_queue_unit_tb.sv */
// Testbench for timed_wait_delta_queue_unit: directed and random command beats
// checked against an in-bench model of the delta list. Depends on twdq_pkg.
`timescale 1ns / 100ps

module timed_wait_delta_queue_unit_tb;
    import twdq_pkg::*;

    localparam int unsigned Cap = 16;
    localparam int unsigned WatchLimit = 20000;

    typedef struct packed {
        logic [IdW-1:0] tid;
        t_reason        why;
        logic           last;
    } t_release;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [1:0]       i_operation;
    logic [IdW-1:0]   i_task_id;
    logic [DeltaW-1:0] i_timeout;
    logic             o_valid;
    logic             i_stall;
    logic [IdW-1:0]   o_released_id;
    logic [1:0]       o_reason;
    logic             o_last;

    logic [IdW-1:0] wait_tid[Cap];
    int unsigned    wait_delta[Cap];
    logic           wait_forever[Cap];
    int unsigned    wait_count;

    t_release    release_q[$];
    int unsigned fail_count;
    int unsigned release_seen;
    int unsigned idle_cycles;
    int unsigned idle_pct;
    logic        timed_out;

    timed_wait_delta_queue_unit #(.CAPACITY(Cap)) u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report(input string msg);
        $display("tb: mismatch: %s", msg);
        fail_count++;
    endtask

    function automatic void drop_entry(input int unsigned pos);
        int unsigned s;
        if (pos + 1 < wait_count && !wait_forever[pos+1]) begin
            s = wait_delta[pos+1] + wait_delta[pos];
            wait_delta[pos+1] = (s > 65535) ? 65535 : s;
        end
        for (int unsigned i = pos; i + 1 < wait_count; i++) begin
            wait_tid[i] = wait_tid[i+1];
            wait_delta[i] = wait_delta[i+1];
            wait_forever[i] = wait_forever[i+1];
        end
        wait_count--;
    endfunction

    function automatic void place_entry(input int unsigned pos, input logic [IdW-1:0] tid,
                                        input int unsigned delta, input logic fvr);
        for (int unsigned i = wait_count; i > pos; i--) begin
            wait_tid[i] = wait_tid[i-1];
            wait_delta[i] = wait_delta[i-1];
            wait_forever[i] = wait_forever[i-1];
        end
        wait_tid[pos] = tid;
        wait_delta[pos] = delta;
        wait_forever[pos] = fvr;
        wait_count++;
    endfunction

    function automatic void predict_command(input t_op op, input logic [IdW-1:0] tid,
                                            input logic [DeltaW-1:0] tmo);
        int unsigned pos;
        int unsigned rem;
        int unsigned n;
        n = 0;
        case (op)
            OP_INSERT: begin
                if (wait_count >= Cap) begin
                    release_q.push_back('{tid, RSN_FULL, 1'b1});
                end else if (tmo == 0) begin
                    place_entry(wait_count, tid, 0, 1'b1);
                end else begin
                    pos = wait_count;
                    rem = tmo;
                    for (int unsigned i = 0; i < wait_count; i++) begin
                        if (wait_forever[i] || wait_delta[i] > rem) begin
                            pos = i;
                            break;
                        end
                        rem -= wait_delta[i];
                    end
                    if (pos < wait_count && !wait_forever[pos]) wait_delta[pos] -= rem;
                    place_entry(pos, tid, rem, 1'b0);
                end
            end
            OP_SIGNAL: begin
                if (wait_count > 0) begin
                    release_q.push_back('{wait_tid[0], RSN_SIGNAL, 1'b1});
                    drop_entry(0);
                end
            end
            OP_TICK: begin
                if (wait_count > 0 && !wait_forever[0]) begin
                    if (wait_delta[0] > 0) wait_delta[0]--;
                    while (n < MaxResults && wait_count > 0 && !wait_forever[0]
                           && wait_delta[0] == 0) begin
                        release_q.push_back('{wait_tid[0], RSN_TIMEOUT, 1'b0});
                        n++;
                        drop_entry(0);
                    end
                    if (n > 0) release_q[$].last = 1'b1;
                end
            end
            default: begin
                for (int unsigned i = 0; i < wait_count; i++) begin
                    if (wait_tid[i] == tid) begin
                        release_q.push_back('{tid, RSN_REMOVED, 1'b1});
                        drop_entry(i);
                        break;
                    end
                end
            end
        endcase
    endfunction

    task automatic send_command(input t_op op, input logic [IdW-1:0] tid,
                                input logic [DeltaW-1:0] tmo);
        while ($urandom_range(99) < idle_pct) @(negedge i_clk);
        i_valid = 1'b1;
        i_operation = op;
        i_task_id = tid;
        i_timeout = tmo;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_command(op, tid, tmo);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic drain_releases();
        while (release_q.size() != 0) @(negedge i_clk);
        repeat (2 * Cap + 8) @(negedge i_clk);
    endtask

    // receive side: random stall, compare every beat
    always @(negedge i_clk) begin
        i_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
    end

    always @(posedge i_clk) begin
        t_release exp_rel;
        if (i_rst_n && o_valid && !i_stall) begin
            release_seen++;
            if (release_q.size() == 0) begin
                report($sformatf("unexpected beat id %0d", o_released_id));
            end else begin
                exp_rel = release_q.pop_front();
                if (o_released_id !== exp_rel.tid || o_reason !== exp_rel.why
                    || o_last !== exp_rel.last)
                    report($sformatf("got id %0d rsn %0d last %0b, want %0d %0d %0b",
                                     o_released_id, o_reason, o_last,
                                     exp_rel.tid, exp_rel.why, exp_rel.last));
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit && !timed_out) begin
            timed_out = 1'b1;
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_fill_and_full();
        send_command(OP_INSERT, 10'h3FF, 16'hFFFF);
        send_command(OP_INSERT, 10'h000, 16'h0001);
        send_command(OP_INSERT, 10'h155, 16'h0000);
        for (int i = 0; i < Cap - 3; i++)
            send_command(OP_INSERT, 10'(i + 1), 16'($urandom_range(1, 4)));
        send_command(OP_INSERT, 10'h2AA, 16'h0005);
        send_command(OP_REMOVE, 10'h155, 16'hFFFF);
        send_command(OP_REMOVE, 10'h3FE, 16'h0000);
        send_command(OP_SIGNAL, 10'h3FF, 16'h0000);
        // a tick releases many at once
        repeat (5) send_command(OP_TICK, 10'h0, 16'h0);
        while (wait_count > 0) send_command(OP_SIGNAL, 10'h0, 16'h0);
        send_command(OP_SIGNAL, 10'h0, 16'h0);
        send_command(OP_TICK, 10'h0, 16'h0);
        drain_releases();
    endtask

    task automatic test_saturation();
        send_command(OP_INSERT, 10'd7, 16'hFFFF);
        send_command(OP_INSERT, 10'd8, 16'hFFFF);
        send_command(OP_INSERT, 10'd9, 16'hFFFE);
        send_command(OP_SIGNAL, 10'd0, 16'd0);
        send_command(OP_REMOVE, 10'd7, 16'd0);
        send_command(OP_REMOVE, 10'd8, 16'd0);
        send_command(OP_INSERT, 10'd4, 16'h0000);
        send_command(OP_TICK, 10'd0, 16'd0);
        send_command(OP_SIGNAL, 10'd0, 16'd0);
        drain_releases();
    endtask

    task automatic test_random(input int unsigned count, input int unsigned pct);
        int unsigned r;
        logic [IdW-1:0] tid;
        idle_pct = pct;
        for (int unsigned k = 0; k < count; k++) begin
            r = $urandom_range(99);
            tid = (wait_count > 0 && $urandom_range(1)) ? wait_tid[$urandom_range(wait_count-1)]
                                                      : 10'($urandom);
            if (r < 40)
                send_command(OP_INSERT, ($urandom_range(3) == 0) ? 10'($urandom_range(3)) : tid,
                             ($urandom_range(9) == 0) ? 16'($urandom) :
                             ($urandom_range(5) == 0) ? 16'd0 : 16'($urandom_range(1, 6)));
            else if (r < 55) send_command(OP_SIGNAL, 10'($urandom), 16'($urandom));
            else if (r < 85) send_command(OP_TICK, 10'($urandom), 16'($urandom));
            else send_command(OP_REMOVE, tid, 16'($urandom));
            // at the halfway point, hold the sender until every result is back
            if (k == count / 2) while (release_q.size() != 0) @(negedge i_clk);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_operation = OP_INSERT;
        i_task_id = '0;
        i_timeout = '0;
        i_stall = 1'b0;
        fail_count = 0;
        release_seen = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        idle_pct = 17;
        wait_count = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_fill_and_full();
        test_saturation();
        test_random(70, 17);
        test_random(60, 0);
        idle_pct = 17;
        drain_releases();
        $display("tb: covered insert/full/signal/tick/remove, saturation, %0d result beats",
                 release_seen);
        $display("tb: %0d mismatches", fail_count);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
